[src/olt_pkg.sv]
// ----------------------------------------------------------------------------
// olt_pkg: shared types and constants of the ordered list table
// Holds the request codes, status codes, default depth and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package olt_pkg;

  localparam int DefaultDepth = 256;

  typedef enum logic [3:0] {
    FN_ADD      = 4'd0,
    FN_CLEAR    = 4'd1,
    FN_DELETE   = 4'd2,
    FN_INDEX_OF = 4'd3,
    FN_INSERT   = 4'd4,
    FN_EXCHANGE = 4'd5,
    FN_MOVE     = 4'd6,
    FN_REMOVE   = 4'd7,
    FN_READ     = 4'd8,
    FN_COUNT    = 4'd9
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Datapath operation selected by the controller.
  typedef enum logic [3:0] {
    DP_IDLE      = 4'd0,
    DP_LOAD_IDX  = 4'd1,
    DP_LOAD_SCAN = 4'd2,
    DP_LOAD_INS  = 4'd3,
    DP_SCAN      = 4'd4,
    DP_HOLD_DN   = 4'd5,
    DP_HOLD_UP   = 4'd6,
    DP_SHIFT_DN  = 4'd7,
    DP_SHIFT_UP  = 4'd8,
    DP_WRITE     = 4'd9,
    DP_READ_SEC  = 4'd10,
    DP_SWAP_A    = 4'd11
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   cnt_inc;
    logic   cnt_dec;
    logic   cnt_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;   // scan compare matched
  } dp_stat_t;

endpackage

[src/olt_datapath.sv]
// ----------------------------------------------------------------------------
// olt_datapath: list memory, count and walk pointer
// Executes one controller command a cycle: scans, shifts one entry a cycle,
// reads and writes the list memory through a registered read port.
// ----------------------------------------------------------------------------
module olt_datapath import olt_pkg::*; #(
  parameter int LIST_DEPTH = DefaultDepth,
  parameter int AW = $clog2(LIST_DEPTH),
  parameter int CW = $clog2(LIST_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  dp_cmd_t       cmd,
  input  logic [7:0]    in_index,
  input  logic [7:0]    in_second,
  input  logic [31:0]   in_item,
  output dp_stat_t      stat,
  output logic [CW-1:0] cnt,
  output logic [CW-1:0] ptr,
  output logic [31:0]   rdata
);

  logic [31:0]   mem [LIST_DEPTH];
  logic [31:0]   item_r;
  logic [CW-1:0] sec_r;

  // Count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - CW'(1);
    end
  end

  // Walk pointer, held item and memory port. During a shift walk rdata holds
  // the entry that the next write needs, so a shift beat writes rdata at ptr
  // and reads the entry two places further along the walk.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD_IDX: begin
        ptr    <= CW'(in_index);
        sec_r  <= CW'(in_second);
        item_r <= in_item;
        rdata  <= mem[AW'(in_index)];
      end
      DP_LOAD_SCAN: begin
        ptr    <= '0;
        item_r <= in_item;
        rdata  <= mem[0];
      end
      DP_LOAD_INS: begin
        ptr    <= cnt;
        item_r <= in_item;
        rdata  <= mem[AW'(cnt - CW'(1))];
      end
      DP_SCAN: begin
        ptr   <= ptr + CW'(1);
        rdata <= mem[AW'(ptr + CW'(1))];
      end
      DP_HOLD_DN: begin
        item_r <= rdata;
        rdata  <= mem[AW'(ptr + CW'(1))];
      end
      DP_HOLD_UP: begin
        item_r <= rdata;
        rdata  <= mem[AW'(ptr - CW'(1))];
      end
      DP_SHIFT_DN: begin
        mem[AW'(ptr)] <= rdata;
        rdata         <= mem[AW'(ptr + CW'(2))];
        ptr           <= ptr + CW'(1);
      end
      DP_SHIFT_UP: begin
        mem[AW'(ptr)] <= rdata;
        rdata         <= mem[AW'(ptr - CW'(2))];
        ptr           <= ptr - CW'(1);
      end
      DP_WRITE: begin
        mem[AW'(ptr)] <= item_r;
      end
      DP_READ_SEC: begin
        item_r <= rdata;
        rdata  <= mem[AW'(sec_r)];
      end
      DP_SWAP_A: begin
        mem[AW'(ptr)] <= rdata;
        ptr           <= sec_r;
      end
      default: begin
      end
    endcase
  end

  // Search compare against the held handle.
  assign stat.hit = (rdata == item_r);

endmodule

[src/olt_ctrl.sv]
// ----------------------------------------------------------------------------
// olt_ctrl: request sequencer of the ordered list table
// Decodes a request, checks its range, steps the datapath one command a cycle
// and forms the result beat.
// ----------------------------------------------------------------------------
module olt_ctrl import olt_pkg::*; #(
  parameter int LIST_DEPTH = DefaultDepth,
  parameter int CW = $clog2(LIST_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [3:0]    func,
  input  logic [7:0]    index,
  input  logic [7:0]    second_index,
  input  logic [CW-1:0] cnt,
  input  logic [CW-1:0] ptr,
  input  logic [31:0]   rdata,
  input  dp_stat_t      stat,
  output dp_cmd_t       cmd,
  output logic          busy,
  output logic          done,
  output logic [1:0]    status,
  output logic [7:0]    found_index,
  output logic [31:0]   item_out
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_SCAN   = 12'b000000000010,
    S_PRE_DN = 12'b000000000100,
    S_DEL    = 12'b000000001000,
    S_MV     = 12'b000000010000,
    S_MDN    = 12'b000000100000,
    S_UP     = 12'b000001000000,
    S_XA     = 12'b000010000000,
    S_XB     = 12'b000100000000,
    S_XC     = 12'b001000000000,
    S_RD     = 12'b010000000000,
    S_FIN    = 12'b100000000000
  } state_t;

  state_t        state;
  logic [3:0]    fn;
  logic [CW-1:0] stop_pos;
  logic          idx_past_end, idx_at_or_past_end, idx2_past_end, is_full;

  assign busy = (state != S_IDLE);

  // Range checks of the request fields against the current count.
  assign idx_at_or_past_end = (32'(index) >= 32'(cnt));
  assign idx_past_end       = (32'(index) > 32'(cnt));
  assign idx2_past_end      = (32'(second_index) >= 32'(cnt));
  assign is_full            = (32'(cnt) >= 32'(LIST_DEPTH));

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      fn          <= FN_COUNT;
      stop_pos    <= '0;
      status      <= ST_OK;
      found_index <= '0;
      item_out    <= '0;
    end else begin
      done <= (state == S_FIN);
      case (state)
        S_IDLE: begin
          if (start) begin
            fn          <= func;
            status      <= ST_OK;
            found_index <= '0;
            item_out    <= '0;
            case (func)
              FN_ADD: begin
                if (is_full) begin
                  status <= ST_FULL;
                  state  <= S_FIN;
                end else begin
                  found_index <= 8'(cnt);
                  stop_pos    <= cnt;
                  state       <= S_UP;
                end
              end
              FN_DELETE: begin
                if (idx_at_or_past_end) begin
                  status <= ST_RANGE;
                  state  <= S_FIN;
                end else begin
                  state <= S_PRE_DN;
                end
              end
              FN_READ: begin
                if (idx_at_or_past_end) begin
                  status <= ST_RANGE;
                  state  <= S_FIN;
                end else begin
                  state <= S_RD;
                end
              end
              FN_INDEX_OF, FN_REMOVE: begin
                state <= S_SCAN;
              end
              FN_INSERT: begin
                if (idx_past_end) begin
                  status <= ST_RANGE;
                  state  <= S_FIN;
                end else if (is_full) begin
                  status <= ST_FULL;
                  state  <= S_FIN;
                end else begin
                  stop_pos <= CW'(index);
                  state    <= S_UP;
                end
              end
              FN_EXCHANGE: begin
                if (idx_at_or_past_end || idx2_past_end) begin
                  status <= ST_RANGE;
                  state  <= S_FIN;
                end else if (index == second_index) begin
                  state <= S_FIN;
                end else begin
                  state <= S_XA;
                end
              end
              FN_MOVE: begin
                if (idx_at_or_past_end || idx2_past_end) begin
                  status <= ST_RANGE;
                  state  <= S_FIN;
                end else if (index == second_index) begin
                  state <= S_FIN;
                end else begin
                  stop_pos <= CW'(second_index);
                  state    <= S_MV;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_SCAN: begin
          // rdata holds the entry at ptr.
          if (ptr >= cnt) begin
            status <= ST_NOTFOUND;
            state  <= S_FIN;
          end else if (stat.hit) begin
            found_index <= 8'(ptr);
            state       <= (fn == FN_REMOVE) ? S_PRE_DN : S_FIN;
          end
        end
        S_PRE_DN: state <= S_DEL;
        S_DEL: begin
          if (ptr + CW'(1) >= cnt) begin
            state <= S_FIN;
          end
        end
        S_MV: state <= (ptr < stop_pos) ? S_MDN : S_UP;
        S_MDN: begin
          if (ptr >= stop_pos) begin
            state <= S_FIN;
          end
        end
        S_UP: begin
          if (ptr <= stop_pos) begin
            state <= S_FIN;
          end
        end
        S_XA: state <= S_XB;
        S_XB: state <= S_XC;
        S_XC: state <= S_FIN;
        S_RD: begin
          item_out <= rdata;
          state    <= S_FIN;
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command decode, one datapath command per cycle.
  always_comb begin
    cmd = '{op: DP_IDLE, cnt_inc: 1'b0, cnt_dec: 1'b0, cnt_clr: 1'b0};
    case (state)
      S_IDLE: begin
        if (start) begin
          case (func)
            FN_ADD, FN_INSERT:      cmd.op = DP_LOAD_INS;
            FN_INDEX_OF, FN_REMOVE: cmd.op = DP_LOAD_SCAN;
            FN_DELETE, FN_READ, FN_EXCHANGE, FN_MOVE: cmd.op = DP_LOAD_IDX;
            FN_CLEAR:               cmd.cnt_clr = 1'b1;
            default:                cmd.op = DP_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (ptr < cnt && !stat.hit) begin
          cmd.op = DP_SCAN;
        end
      end
      S_PRE_DN: cmd.op = DP_HOLD_DN;
      S_DEL: begin
        if (ptr + CW'(1) < cnt) begin
          cmd.op = DP_SHIFT_DN;
        end else begin
          cmd.cnt_dec = 1'b1;
        end
      end
      S_MV: cmd.op = (ptr < stop_pos) ? DP_HOLD_DN : DP_HOLD_UP;
      S_MDN: cmd.op = (ptr < stop_pos) ? DP_SHIFT_DN : DP_WRITE;
      S_UP: begin
        if (ptr > stop_pos) begin
          cmd.op = DP_SHIFT_UP;
        end else begin
          // A move keeps its count; insert and add grow the list.
          cmd.op      = DP_WRITE;
          cmd.cnt_inc = (fn != FN_MOVE);
        end
      end
      S_XA: cmd.op = DP_READ_SEC;
      S_XB: cmd.op = DP_SWAP_A;
      S_XC: cmd.op = DP_WRITE;
      default: cmd.op = DP_IDLE;
    endcase
  end

  // A result beat always closes a busy period.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");
  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(LIST_DEPTH))
    else $error("count above capacity");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted request did not start");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

[src/ordered_list_table.sv]
// ----------------------------------------------------------------------------
// ordered_list_table: fixed-capacity ordered list of 32-bit handles
// Channel   | Handshake     | Fields
// request   | start / busy  | func, index, second_index, item
// result    | done strobe   | status, found_index, item_out, count
// The result strobe follows the accepted beat once the walk over the list
// memory, if any (search, shift on insert, delete and move, one entry a
// cycle), is done. A new request can be taken in the strobe cycle.
// Reset is synchronous on rst and clears the count and the sequencer.
// busy stays high from the accepted beat until the result strobe.
// The receiver cannot stall: each result stands for one cycle.
// ----------------------------------------------------------------------------
module ordered_list_table import olt_pkg::*; #(
  parameter int LIST_DEPTH = DefaultDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  func,
  input  logic [7:0]  index,
  input  logic [7:0]  second_index,
  input  logic [31:0] item,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  found_index,
  output logic [31:0] item_out,
  output logic [8:0]  count
);

  localparam int CW = $clog2(LIST_DEPTH + 1);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [CW-1:0] cnt;
  logic [CW-1:0] ptr;
  logic [31:0]   rdata;

  olt_datapath #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
    .clk, .rst, .cmd, .in_index(index), .in_second(second_index),
    .in_item(item), .stat, .cnt, .ptr, .rdata
  );

  olt_ctrl #(.LIST_DEPTH(LIST_DEPTH)) u_ctrl (
    .clk, .rst, .start, .func, .index, .second_index, .cnt, .ptr, .rdata,
    .stat, .cmd, .busy, .done, .status, .found_index, .item_out
  );

  assign count = 9'(cnt);

endmodule
